/* rtl/ithn_pkg.sv */
// Shared types, register indexes and one's-complement helpers for the header normalizer.
package ithn_pkg;

	// Register indexes on the configuration port
	localparam int unsigned CfgIdxW = 2;
	localparam logic [CfgIdxW-1:0] REG_MIN_TTL      = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_MAX_MSS      = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_RANDOMIZE_ID = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_CLEAR_DF     = 2'd3;
	localparam int unsigned CfgDataW = 16;

	// Don't-fragment flag in the flags/fragment word
	localparam logic [15:0] DF_BIT = 16'h4000;

	// One parsed header coming in
	typedef struct packed {
		logic        already_blocked;
		logic        is_ipv4;
		logic [15:0] ip_ident;
		logic [15:0] flags_fragment;
		logic [7:0]  time_to_live;
		logic [15:0] ip_header_sum;
		logic [15:0] fresh_ident;
		logic        tcp_syn;
		logic [15:0] mss_value;
		logic        mss_odd_offset;
		logic [15:0] tcp_sum;
		logic        checksum_deferred;
	} hdr_t;

	// Rewritten header going out
	typedef struct packed {
		logic [15:0] out_ip_ident;
		logic [15:0] out_flags_fragment;
		logic [7:0]  out_time_to_live;
		logic [15:0] out_ip_header_sum;
		logic [15:0] out_mss_value;
		logic [15:0] out_tcp_sum;
		logic        ip_rewritten;
		logic        mss_clamped;
	} res_t;

	// Configuration register contents
	typedef struct packed {
		logic [7:0]  min_ttl;
		logic [15:0] max_mss;
		logic        randomize_id;
		logic        clear_df;
	} cfg_t;

	// Incremental checksum update: HC' = ~(~HC + ~m + m'), end-around carry folded twice
	function automatic logic [15:0] oc_fix(input logic [15:0] sum, input logic [15:0] oldv,
		input logic [15:0] newv);
		logic [17:0] s;
		logic [16:0] f;
		s = {2'b00, ~sum} + {2'b00, ~oldv} + {2'b00, newv};
		f = {1'b0, s[15:0]} + {15'd0, s[17:16]};
		f = f + {16'd0, f[16]};
		return ~f[15:0];
	endfunction

	function automatic logic [15:0] swap16(input logic [15:0] v);
		return {v[7:0], v[15:8]};
	endfunction

endpackage

/* rtl/ithn_cfg_regs.sv */
// Configuration register file for the header normalizer.
module ithn_cfg_regs import ithn_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [CfgIdxW-1:0] wr_index,
	input  logic [CfgDataW-1:0] wr_data,
	output cfg_t               cfg
);

	cfg_t cfg_q;

	// Register writes, one field per index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_MIN_TTL:      cfg_q.min_ttl      <= wr_data[7:0];
				REG_MAX_MSS:      cfg_q.max_mss      <= wr_data[15:0];
				REG_RANDOMIZE_ID: cfg_q.randomize_id <= wr_data[0];
				REG_CLEAR_DF:     cfg_q.clear_df     <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/ithn_ip_rewrite.sv */
// IPv4 rewrite: ID replacement, DF clear and TTL floor with header checksum update.
module ithn_ip_rewrite import ithn_pkg::*; (
	input  hdr_t        hdr,
	input  cfg_t        cfg,
	output logic [15:0] ip_ident,
	output logic [15:0] flags_fragment,
	output logic [7:0]  time_to_live,
	output logic [15:0] ip_header_sum,
	output logic        ip_rewritten
);

	logic        ip_en;
	logic [15:0] sum_a;
	logic [15:0] sum_b;
	logic [15:0] ffw_clr;
	logic        do_id;
	logic        do_df;
	logic        do_ttl;

	// Any IPv4 rewrite enabled for an unblocked IPv4 header
	assign ip_en  = hdr.is_ipv4 && !hdr.already_blocked &&
		(cfg.randomize_id || cfg.clear_df || (cfg.min_ttl != 8'd0));
	assign do_id  = ip_en && cfg.randomize_id;
	assign do_df  = ip_en && cfg.clear_df && ((hdr.flags_fragment & DF_BIT) != 16'd0);
	assign do_ttl = ip_en && (cfg.min_ttl != 8'd0) && (hdr.time_to_live < cfg.min_ttl);

	assign ffw_clr = hdr.flags_fragment & ~DF_BIT;

	// Checksum chain in the fixed order ID, DF, TTL
	always_comb begin
		sum_a = hdr.ip_header_sum;
		if (do_id) begin
			sum_a = oc_fix(hdr.ip_header_sum, hdr.ip_ident, hdr.fresh_ident);
		end
		sum_b = sum_a;
		if (do_df) begin
			sum_b = oc_fix(sum_a, hdr.flags_fragment, ffw_clr);
		end
		ip_header_sum = sum_b;
		if (do_ttl) begin
			// TTL is the high byte of its checksum word
			ip_header_sum = oc_fix(sum_b, {hdr.time_to_live, 8'h00}, {cfg.min_ttl, 8'h00});
		end
	end

	assign ip_ident       = do_id ? hdr.fresh_ident : hdr.ip_ident;
	assign flags_fragment = do_df ? ffw_clr : hdr.flags_fragment;
	assign time_to_live   = do_ttl ? cfg.min_ttl : hdr.time_to_live;
	assign ip_rewritten   = do_id || do_df || do_ttl;

endmodule

/* rtl/ithn_mss_clamp.sv */
// TCP SYN MSS clamp with incremental TCP checksum update.
module ithn_mss_clamp import ithn_pkg::*; (
	input  hdr_t        hdr,
	input  cfg_t        cfg,
	output logic [15:0] mss_value,
	output logic [15:0] tcp_sum,
	output logic        mss_clamped
);

	logic        do_clamp;
	logic [15:0] old_w;
	logic [15:0] new_w;

	assign do_clamp = !hdr.already_blocked && hdr.tcp_syn && (cfg.max_mss != 16'd0) &&
		(hdr.mss_value > cfg.max_mss);

	// MSS straddling two checksum words enters the sum byte-swapped
	assign old_w = hdr.mss_odd_offset ? swap16(hdr.mss_value) : hdr.mss_value;
	assign new_w = hdr.mss_odd_offset ? swap16(cfg.max_mss) : cfg.max_mss;

	assign tcp_sum     = (do_clamp && !hdr.checksum_deferred) ?
		oc_fix(hdr.tcp_sum, old_w, new_w) : hdr.tcp_sum;
	assign mss_value   = do_clamp ? cfg.max_mss : hdr.mss_value;
	assign mss_clamped = do_clamp;

endmodule

/* rtl/ip_tcp_header_normalizer_top.sv */
// Top level of the IPv4/TCP header normalizer: config port, input and result registers.
//
// One header word is accepted per clock while in_ready is high. The accepting edge
// puts the header in the input register; a later edge, when the result register takes
// it, captures the rewrite (ID, DF, TTL and MSS with their checksum updates) into the
// result register behind out_data. The input register holds only while full with the
// result register stalled, so a new header still enters an empty input register while a
// result waits for out_ready. Configuration registers reset to zero (all rewrites off)
// and are written through the cfg port, which is always ready; write them only while idle.
module ip_tcp_header_normalizer_top import ithn_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  hdr_t                in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output res_t                out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	cfg_t cfg;
	hdr_t hdr_s1;
	logic vld_s1;
	res_t res_s2;
	logic vld_s2;
	res_t res_c;
	logic take_s2;

	assign cfg_ready = 1'b1;

	ithn_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Rewrite logic between the two registers
	ithn_ip_rewrite u_ip (
		.hdr            (hdr_s1),
		.cfg            (cfg),
		.ip_ident       (res_c.out_ip_ident),
		.flags_fragment (res_c.out_flags_fragment),
		.time_to_live   (res_c.out_time_to_live),
		.ip_header_sum  (res_c.out_ip_header_sum),
		.ip_rewritten   (res_c.ip_rewritten)
	);

	ithn_mss_clamp u_mss (
		.hdr         (hdr_s1),
		.cfg         (cfg),
		.mss_value   (res_c.out_mss_value),
		.tcp_sum     (res_c.out_tcp_sum),
		.mss_clamped (res_c.mss_clamped)
	);

	// Stage handshake: each stage loads when empty or when its word moves on
	assign take_s2  = !vld_s2 || out_ready;
	assign in_ready = !vld_s1 || take_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				vld_s1 <= in_valid;
			end
			if (take_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			hdr_s1 <= in_data;
		end
		if (take_s2 && vld_s1) begin
			res_s2 <= res_c;
		end
	end

	assign out_valid = vld_s2;
	assign out_data  = res_s2;

	// An empty input stage never refuses a word
	a_s1_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s1 |-> in_ready)
		else $error("input stage empty but not ready");

	// A stalled input-stage word is still there next cycle
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !take_s2 |=> vld_s1)
		else $error("input stage word dropped while stalled");

	// A clamped MSS equals the nonzero limit
	a_clamp_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.mss_clamped |->
			(out_data.out_mss_value == cfg.max_mss) && (cfg.max_mss != 16'd0))
		else $error("clamped MSS differs from limit");

	// No IPv4 rewrite is reported with every IPv4 rewrite disabled
	a_ip_disabled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.ip_rewritten |->
			cfg.randomize_id || cfg.clear_df || (cfg.min_ttl != 8'd0))
		else $error("IPv4 rewrite flagged while disabled");

endmodule
